>>> rtl/rimp_pkg.sv
// package for the repeat interval membership penalty block
// codes, field widths and reset values; no dependencies
`default_nettype none

package rimp_pkg;

  // default table depth
  localparam int unsigned MaxIntervalsDef = 4096;

  // field widths
  localparam int unsigned OpW     = 2;
  localparam int unsigned CoordW  = 32;
  localparam int unsigned PosW    = 31;
  localparam int unsigned PenW    = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 31;

  // packed stream widths
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 56;

  // operation codes
  localparam logic [OpW-1:0] OpLoad    = 2'd0;
  localparam logic [OpW-1:0] OpQuery   = 2'd1;
  localparam logic [OpW-1:0] OpRestart = 2'd2;

  // status codes
  localparam logic [StatusW-1:0] StatOk   = 2'd0;
  localparam logic [StatusW-1:0] StatBad  = 2'd1;
  localparam logic [StatusW-1:0] StatFull = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegSeqLen = 2'd0;
  localparam logic [CfgIdxW-1:0] RegExon   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegIntron = 2'd2;
  localparam logic [CfgIdxW-1:0] RegUtr    = 2'd3;

  localparam logic [PosW-1:0] SeqLenReset = 31'h7fff_ffff;

endpackage

`default_nettype wire

>>> rtl/repeat_interval_membership_penalty.sv
// top level of the repeat interval membership penalty block
// interval tables, load checks, binary search and cursor sequencer; uses rimp_pkg
`default_nettype none

// Keeps up to MAX_INTERVALS sorted, non-overlapping, zero-based inclusive
// intervals in two on-chip memories (starts and ends) and answers position
// queries with the exon, intron and UTR penalties on a hit, zeros on a miss.
// The operation rides on s_axis_tuser: load appends one interval after
// clipping it to [1, sequence_length] and checking order and overlap against
// the last stored end; query looks the position up; restart clears the cursor.
// One item is in work at a time and s_axis_tready is high only while the
// sequencer is idle. Every memory look-up has a registered read (address,
// then registered read data), and separate compares do the load, search and
// hit checks. A load goes from idle through the load check to its result. A
// query at the previous position plus one follows the running cursor through
// the hit check (skipped once the cursor has passed the last interval); any
// other query runs a binary search over the end table first, a probe and a
// compare per halving step, then the hit check, skipped when the position
// lies past the last stored end. A query on an empty table, a restart or an
// unused operation goes straight to the result. A result waits in the output
// register until it is taken; the next item may be accepted meanwhile but its
// result is held back until the output register frees. Tables need no clearing
// after reset: only written entries are ever used.
module repeat_interval_membership_penalty #(
  parameter int unsigned MAX_INTERVALS = rimp_pkg::MaxIntervalsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration writes
  input  wire logic                          cfg_we_i,
  input  wire logic [rimp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [rimp_pkg::CfgW-1:0]     cfg_data_i,
  // input items
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // interval_start [31:0], interval_end [63:32], query_position [94:64], zero pad
  input  wire logic [rimp_pkg::InDataW-1:0]  s_axis_tdata,
  // operation [1:0]
  input  wire logic [rimp_pkg::OpW-1:0]      s_axis_tuser,
  // results
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // in_repeat [0], exon_amount [16:1], intron_amount [32:17],
  // utr_amount [48:33], status [50:49], zero pad
  output logic [rimp_pkg::OutDataW-1:0]      m_axis_tdata
);
  import rimp_pkg::*;

  localparam int unsigned AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);
  localparam logic [CW-1:0] CntMax = CW'(MAX_INTERVALS);

  // sequencer states
  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StLdChk   = 3'd1;
  localparam logic [2:0] StSrch    = 3'd2;
  localparam logic [2:0] StSrchCmp = 3'd3;
  localparam logic [2:0] StQChk    = 3'd4;
  localparam logic [2:0] StDone    = 3'd5;

  // configuration registers
  logic [PosW-1:0] seq_len_q;
  logic [PenW-1:0] exon_pen_q, intron_pen_q, utr_pen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_len_q    <= SeqLenReset;
      exon_pen_q   <= '0;
      intron_pen_q <= '0;
      utr_pen_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegSeqLen: seq_len_q    <= cfg_data_i;
        RegExon:   exon_pen_q   <= cfg_data_i[PenW-1:0];
        RegIntron: intron_pen_q <= cfg_data_i[PenW-1:0];
        RegUtr:    utr_pen_q    <= cfg_data_i[PenW-1:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [OpW-1:0]           in_op;
  logic signed [CoordW-1:0] in_start, in_end;
  logic [PosW-1:0]          in_pos;

  assign in_op    = s_axis_tuser;
  assign in_start = s_axis_tdata[31:0];
  assign in_end   = s_axis_tdata[63:32];
  assign in_pos   = s_axis_tdata[94:64];

  // state
  logic [2:0]         state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      cursor_q, cursor_d;
  logic [PosW-1:0]    last_pos_q, last_pos_d;
  logic               last_valid_q, last_valid_d;
  logic [CW-1:0]      lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [PosW-1:0]    pos_q, pos_d;     // query position or clipped start
  logic [PosW-1:0]    ld_end_q, ld_end_d;
  logic               ld_bad_q, ld_bad_d;
  logic               res_hit_q, res_hit_d;
  logic [StatusW-1:0] res_stat_q, res_stat_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic              out_hit_q, out_hit_d;
  logic [PenW-1:0]   out_exon_q, out_exon_d, out_intron_q, out_intron_d;
  logic [PenW-1:0]   out_utr_q, out_utr_d;
  logic [StatusW-1:0] out_stat_q, out_stat_d;

  // interval memories, one write and one registered read port each
  logic [PosW-1:0] start_mem [MAX_INTERVALS];
  logic [PosW-1:0] end_mem [MAX_INTERVALS];
  logic [PosW-1:0] rd_start_q, rd_end_q;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic            wr_en;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      start_mem[wr_addr] <= pos_q;
      end_mem[wr_addr]   <= ld_end_q;
    end
    rd_start_q <= start_mem[rd_addr];
    rd_end_q   <= end_mem[rd_addr];
  end

  assign wr_addr = count_q[AW-1:0];

  // load clipping: start to max(1,s)-1, end to min(seq_len,e)-1
  logic signed [CoordW+1:0] clip_s, clip_e;
  always_comb begin
    clip_s = (in_start < 1) ? (CoordW+2)'(0) : (CoordW+2)'(in_start) - (CoordW+2)'(1);
    if ((CoordW+2)'(in_end) > $signed({3'b000, seq_len_q})) begin
      clip_e = $signed({3'b000, seq_len_q}) - (CoordW+2)'(1);
    end else begin
      clip_e = (CoordW+2)'(in_end) - (CoordW+2)'(1);
    end
  end

  // search compare: midpoint and end below position
  logic [CW-1:0] mid_calc;
  logic          end_below;
  assign mid_calc  = lo_q + ((hi_q - lo_q) >> 1);
  assign end_below = rd_end_q < pos_q;

  logic in_xfer, out_free, jump;
  assign s_axis_tready = (state_q == StIdle);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign jump = !last_valid_q || ({1'b0, in_pos} != {1'b0, last_pos_q} + (PosW+1)'(1));

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    cursor_d     = cursor_q;
    last_pos_d   = last_pos_q;
    last_valid_d = last_valid_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    pos_d        = pos_q;
    ld_end_d     = ld_end_q;
    ld_bad_d     = ld_bad_q;
    res_hit_d    = res_hit_q;
    res_stat_d   = res_stat_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_hit_d    = out_hit_q;
    out_exon_d   = out_exon_q;
    out_intron_d = out_intron_q;
    out_utr_d    = out_utr_q;
    out_stat_d   = out_stat_q;
    wr_en        = 1'b0;
    rd_addr      = cursor_q[AW-1:0];

    case (state_q)
      StIdle: begin
        if (in_op == OpLoad) begin
          rd_addr = AW'(count_q - CW'(1));   // last stored end
        end
        if (in_xfer) begin
          res_hit_d  = 1'b0;
          res_stat_d = StatOk;
          state_d    = StDone;
          case (in_op)
            OpLoad: begin
              pos_d    = clip_s[PosW-1:0];
              ld_end_d = clip_e[PosW-1:0];
              ld_bad_d = clip_s > clip_e;
              state_d  = StLdChk;
            end
            OpQuery: begin
              pos_d        = in_pos;
              last_pos_d   = in_pos;
              last_valid_d = 1'b1;
              if (count_q != '0) begin
                if (jump) begin
                  lo_d    = '0;
                  hi_d    = count_q;
                  state_d = StSrch;
                end else if (cursor_q < count_q) begin
                  state_d = StQChk;            // read at cursor issued now
                end
              end
            end
            OpRestart: begin
              cursor_d     = '0;
              last_valid_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      StLdChk: begin
        if (ld_bad_q || (count_q != '0 && rd_end_q >= pos_q)) begin
          res_stat_d = StatBad;
        end else if (count_q >= CntMax) begin
          res_stat_d = StatFull;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + CW'(1);
        end
        state_d = StDone;
      end
      StSrch: begin
        if (lo_q < hi_q) begin
          rd_addr = mid_calc[AW-1:0];
          mid_d   = mid_calc;
          state_d = StSrchCmp;
        end else begin
          rd_addr  = lo_q[AW-1:0];
          cursor_d = lo_q;
          state_d  = (lo_q < count_q) ? StQChk : StDone;
        end
      end
      StSrchCmp: begin
        if (end_below) begin
          lo_d = mid_q + CW'(1);
        end else begin
          hi_d = mid_q;
        end
        state_d = StSrch;
      end
      StQChk: begin
        if (pos_q >= rd_start_q) begin
          res_hit_d = 1'b1;
          if (pos_q == rd_end_q) begin
            cursor_d = cursor_q + CW'(1);
          end
        end
        state_d = StDone;
      end
      StDone: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_hit_d    = res_hit_q;
          out_exon_d   = res_hit_q ? exon_pen_q : '0;
          out_intron_d = res_hit_q ? intron_pen_q : '0;
          out_utr_d    = res_hit_q ? utr_pen_q : '0;
          out_stat_d   = res_stat_q;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      count_q      <= '0;
      cursor_q     <= '0;
      last_pos_q   <= '0;
      last_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      cursor_q     <= cursor_d;
      last_pos_q   <= last_pos_d;
      last_valid_q <= last_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload and search registers
  always_ff @(posedge clk_i) begin
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    pos_q        <= pos_d;
    ld_end_q     <= ld_end_d;
    ld_bad_q     <= ld_bad_d;
    res_hit_q    <= res_hit_d;
    res_stat_q   <= res_stat_d;
    out_hit_q    <= out_hit_d;
    out_exon_q   <= out_exon_d;
    out_intron_q <= out_intron_d;
    out_utr_q    <= out_utr_d;
    out_stat_q   <= out_stat_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_stat_q, out_utr_q, out_intron_q, out_exon_q, out_hit_q};

  // table never grows past its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntMax)
    else $error("interval count beyond table depth");

  // cursor stays within the filled part of the table
  assert property (@(posedge clk_i) disable iff (!rst_ni) cursor_q <= count_q)
    else $error("cursor beyond interval count");

  // a probe always lies inside the current search window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StSrchCmp |-> (mid_q >= lo_q && mid_q < hi_q))
    else $error("search probe outside window");

  // a miss never carries a penalty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> m_axis_tdata[48:1] == '0)
    else $error("penalty on a miss");

  // the table only changes through a load check
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |-> $past(state_q) == StLdChk)
    else $error("interval count changed outside a load");

endmodule

`default_nettype wire
